FILE: sv/heat_diffusion_stencil_pass_top_defines.svh
// Assertion macros used by the checker file of the diffusion pass.
`ifndef HEAT_DIFFUSION_STENCIL_PASS_TOP_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_PASS_TOP_DEFINES_SVH

// Holds at every clock edge, reset included.
`define HDS_ASSERT_ALWAYS(label, clk_sig, cons, msg) \
    label: assert property (@(posedge clk_sig) (cons)) else $error(msg);

// Consequent in the same cycle as the antecedent, checked out of reset.
`define HDS_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent, checked out of reset.
`define HDS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hds_pkg.sv
`default_nettype none

package hds_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    localparam int CFG_W       = 11;
    localparam int GAIN_W      = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam int TEMP_W      = 32;
    localparam int PAIR_W      = TEMP_W + 1;
    localparam int DIFF_W      = TEMP_W + 3;
    localparam int PROD_W      = DIFF_W + GAIN_W;
    localparam int ROUND_SHIFT = 18;
    localparam int DELTA_W     = PROD_W - ROUND_SHIFT;
    localparam int SUM_W       = DELTA_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT      = 2'd0,
        REG_COLUMN_COUNT   = 2'd1,
        REG_DIFFUSION_GAIN = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W:0]    rows;
        logic [COL_W:0]    cols;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] self_val;
        logic signed [PAIR_W-1:0] lr;
        logic signed [PAIR_W-1:0] ab;
        logic                     last;
    } job_t;

endpackage

`default_nettype wire

FILE: sv/hds_line_store.sv
`default_nettype none

module hds_line_store (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic                               parity,
    input  logic [hds_pkg::COL_W-1:0]          col,
    input  logic [hds_pkg::COL_W-1:0]          ahead_col,
    input  logic signed [hds_pkg::TEMP_W-1:0]  wr_data,
    output logic signed [hds_pkg::TEMP_W-1:0]  above_data,
    output logic signed [hds_pkg::TEMP_W-1:0]  ahead_data
);
    import hds_pkg::*;

    logic [TEMP_W-1:0] bank0 [MAX_COLUMNS];
    logic [TEMP_W-1:0] bank1 [MAX_COLUMNS];
    logic [TEMP_W-1:0] rd0_reg;
    logic [TEMP_W-1:0] rd1_reg;
    logic              parity_reg;
    logic [COL_W-1:0]  addr0;
    logic [COL_W-1:0]  addr1;

    // The bank of the current row is read at the written column before the
    // write lands; the other bank is read one column ahead.
    assign addr0 = parity ? ahead_col : col;
    assign addr1 = parity ? col : ahead_col;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd0_reg <= bank0[addr0];
            if (!parity)
            begin
                bank0[col] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd1_reg <= bank1[addr1];
            if (parity)
            begin
                bank1[col] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parity_reg <= parity;
        end
    end

    assign above_data = parity_reg ? $signed(rd1_reg) : $signed(rd0_reg);
    assign ahead_data = parity_reg ? $signed(rd0_reg) : $signed(rd1_reg);

endmodule

`default_nettype wire

FILE: sv/hds_scan.sv
`default_nettype none

module hds_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hds_pkg::cfg_t                     cfg,
    input  logic                              restart,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hds_pkg::TEMP_W-1:0] in_data,
    output logic                              job_valid,
    input  logic                              job_ready,
    output hds_pkg::job_t                     job
);
    import hds_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [2:0]       pending_reg;
    logic [2:0]       pending_next;
    logic [2:0]       pick;
    logic [2:0]       remaining;

    logic signed [TEMP_W-1:0] v_reg;
    logic signed [TEMP_W-1:0] pm1_reg;
    logic signed [TEMP_W-1:0] p0_reg;
    logic signed [TEMP_W-1:0] cur1_reg;
    logic signed [TEMP_W-1:0] cur2_reg;
    logic signed [TEMP_W-1:0] row_first_reg;
    logic                     r_ge1_reg;
    logic                     r_ge2_reg;
    logic                     c_ge1_reg;
    logic                     c_ge2_reg;
    logic                     c_last_reg;

    logic                     accept;
    logic                     job_fire;
    logic                     last_row;
    logic                     col_last;
    logic                     final_cell;
    logic [COL_W-1:0]         ahead_col;
    logic signed [TEMP_W-1:0] above_data;
    logic signed [TEMP_W-1:0] ahead_data;

    logic signed [TEMP_W-1:0] self_val;
    logic signed [TEMP_W-1:0] left_val;
    logic signed [TEMP_W-1:0] right_val;
    logic signed [TEMP_W-1:0] above_val;
    logic signed [TEMP_W-1:0] below_val;

    assign last_row   = ({1'b0, row_reg} == (cfg.rows - (ROW_W+1)'(1)));
    assign col_last   = ({1'b0, col_reg} == (cfg.cols - (COL_W+1)'(1)));
    assign final_cell = last_row && col_last;
    assign ahead_col  = col_reg + COL_W'(1);

    assign accept    = in_valid && in_ready;
    assign job_valid = |pending_reg;
    assign job_fire  = job_valid && job_ready;
    assign pick      = pending_reg & (~pending_reg + 3'd1);
    assign remaining = job_fire ? (pending_reg & ~pick) : pending_reg;
    assign in_ready  = (remaining == 3'd0);

    hds_line_store u_line_store (
        .clk        (clk),
        .wr_en      (accept),
        .parity     (row_reg[0]),
        .col        (col_reg),
        .ahead_col  (ahead_col),
        .wr_data    (in_data),
        .above_data (above_data),
        .ahead_data (ahead_data)
    );

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (final_cell)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (col_last)
        begin
            row_next = row_reg + ROW_W'(1);
            col_next = '0;
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_comb
    begin
        pending_next = remaining;
        if (accept)
        begin
            pending_next = {final_cell, last_row && (col_reg != '0), row_reg != '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (restart)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // Sliding window around the cell being accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg      <= in_data;
            r_ge1_reg  <= (row_reg != '0);
            r_ge2_reg  <= (row_reg > ROW_W'(1));
            c_ge1_reg  <= (col_reg != '0);
            c_ge2_reg  <= (col_reg > COL_W'(1));
            c_last_reg <= col_last;
            if (col_reg == '0)
            begin
                p0_reg        <= row_first_reg;
                row_first_reg <= in_data;
            end
            else
            begin
                pm1_reg  <= p0_reg;
                p0_reg   <= ahead_data;
                cur2_reg <= cur1_reg;
                cur1_reg <= v_reg;
            end
        end
    end

    always_comb
    begin
        self_val  = v_reg;
        left_val  = c_ge1_reg ? cur1_reg : '0;
        right_val = '0;
        above_val = r_ge1_reg ? p0_reg : '0;
        below_val = '0;
        priority if (pick[0])
        begin
            self_val  = p0_reg;
            left_val  = c_ge1_reg ? pm1_reg : '0;
            right_val = c_last_reg ? '0 : ahead_data;
            above_val = r_ge2_reg ? above_data : '0;
            below_val = v_reg;
        end
        else if (pick[1])
        begin
            self_val  = cur1_reg;
            left_val  = c_ge2_reg ? cur2_reg : '0;
            right_val = v_reg;
            above_val = r_ge1_reg ? pm1_reg : '0;
        end
        else
        begin
            self_val  = v_reg;
        end
    end

    assign job.self_val = self_val;
    assign job.lr       = $signed({left_val[TEMP_W-1], left_val})
                        + $signed({right_val[TEMP_W-1], right_val});
    assign job.ab       = $signed({above_val[TEMP_W-1], above_val})
                        + $signed({below_val[TEMP_W-1], below_val});
    assign job.last     = pick[2];

endmodule

`default_nettype wire

FILE: sv/hds_datapath.sv
`default_nettype none

module hds_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hds_pkg::GAIN_W-1:0]        gain,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  hds_pkg::job_t                     job,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hds_pkg::TEMP_W-1:0] out_data,
    output logic                              out_last
);
    import hds_pkg::*;

    logic                     jv_reg;
    job_t                     job_reg;
    logic                     dv_reg;
    logic signed [TEMP_W-1:0] self_d_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic                     last_d_reg;
    logic                     pv_reg;
    logic signed [TEMP_W-1:0] self_p_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W:0]   prod_full;
    logic                     last_p_reg;
    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] out_data_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     p_ready;
    logic                     d_ready;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]  sum;
    logic signed [TEMP_W-1:0] result;

    assign out_free  = !out_valid_reg || out_ready;
    assign p_ready   = !pv_reg || out_free;
    assign d_ready   = !dv_reg || p_ready;
    assign job_ready = !jv_reg || d_ready;

    assign diff_next = $signed({{2{job_reg.lr[PAIR_W-1]}}, job_reg.lr})
                     + $signed({{2{job_reg.ab[PAIR_W-1]}}, job_reg.ab})
                     - $signed({job_reg.self_val[TEMP_W-1], job_reg.self_val, 2'b00});

    assign prod_full = $signed({1'b0, gain}) * diff_reg;

    // Floor of (product + half) over 2^18: upper bits plus the rounding bit.
    assign delta = prod_reg[PROD_W-1:ROUND_SHIFT];
    assign sum   = $signed({{(SUM_W-TEMP_W){self_p_reg[TEMP_W-1]}}, self_p_reg})
                 + $signed({delta[DELTA_W-1], delta})
                 + $signed({{(SUM_W-1){1'b0}}, prod_reg[ROUND_SHIFT-1]});

    always_comb
    begin
        if ((&sum[SUM_W-1:TEMP_W-1]) || !(|sum[SUM_W-1:TEMP_W-1]))
        begin
            result = sum[TEMP_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            result = TEMP_MIN;
        end
        else
        begin
            result = TEMP_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg        <= 1'b0;
            dv_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                jv_reg <= job_valid;
            end
            if (d_ready)
            begin
                dv_reg <= jv_reg;
            end
            if (p_ready)
            begin
                pv_reg <= dv_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= pv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            job_reg <= job;
        end
        if (d_ready && jv_reg)
        begin
            self_d_reg <= job_reg.self_val;
            diff_reg   <= diff_next;
            last_d_reg <= job_reg.last;
        end
        if (p_ready && dv_reg)
        begin
            self_p_reg <= self_d_reg;
            prod_reg   <= prod_full[PROD_W-1:0];
            last_p_reg <= last_d_reg;
        end
        if (out_free && pv_reg)
        begin
            out_data_reg <= result;
            out_last_reg <= last_p_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/heat_diffusion_stencil_pass_top.sv
`default_nettype none

// Five-point explicit heat-diffusion pass over a grid streamed in raster order: each cell
// becomes self + gain * ((left + right + above + below) / 4 - self), with cells outside the
// grid counted as zero, temperatures in signed Q16.16, gain in unsigned Q1.16 and results
// saturated to 32 bits. A cell is sent out once the cell below it has arrived; in the last
// row once its right neighbor has arrived, and the final word of the grid flushes the rest
// and marks the last result with tlast. Rows and columns are clamped to 1..1024 and the
// gain to 1.0. Configuration is to be written by the user only while the block is idle,
// which the block itself leaves unchecked, and any write to a listed register restarts
// the scan at the grid origin; cfg_ready is always high. Two line banks of 1024 words,
// one per row parity, each give one read a cycle while words are accepted, and a single
// arithmetic lane produces one result a cycle while the output is not stalled. A new word
// is accepted only once the lane takes the last result released by the previous word.
// Each accepted word is registered into the sliding window of the scan, and each result
// it releases then passes the job, difference, product and output registers of the lane
// in that order.
module heat_diffusion_stencil_pass_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hds_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Bits 31:0 temperature.
    input  logic signed [hds_pkg::TEMP_W-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Bits 31:0 new_temperature.
    output logic signed [hds_pkg::TEMP_W-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import hds_pkg::*;

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          restart;
    logic          job_valid;
    logic          job_ready;
    job_t          job;

    function automatic logic [ROW_W:0] clamp_rows(input logic [CFG_W-1:0] v);
        int x;
        x = int'(v);
        if (x < 1)
        begin
            x = 1;
        end
        if (x > MAX_ROWS)
        begin
            x = MAX_ROWS;
        end
        return (ROW_W+1)'(x);
    endfunction

    function automatic logic [COL_W:0] clamp_cols(input logic [CFG_W-1:0] v);
        int x;
        x = int'(v);
        if (x < 1)
        begin
            x = 1;
        end
        if (x > MAX_COLUMNS)
        begin
            x = MAX_COLUMNS;
        end
        return (COL_W+1)'(x);
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ROW_COUNT:
                begin
                    cfg_next.rows = clamp_rows(cfg_data[CFG_W-1:0]);
                    restart       = 1'b1;
                end
                REG_COLUMN_COUNT:
                begin
                    cfg_next.cols = clamp_cols(cfg_data[CFG_W-1:0]);
                    restart       = 1'b1;
                end
                REG_DIFFUSION_GAIN:
                begin
                    cfg_next.gain = (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
                    restart       = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows <= (ROW_W+1)'(1);
            cfg_reg.cols <= (COL_W+1)'(1);
            cfg_reg.gain <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hds_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .restart   (restart),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    hds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (cfg_reg.gain),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/hds_checker.sv
`default_nettype none

`include "heat_diffusion_stencil_pass_top_defines.svh"

module hds_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_ready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic signed [hds_pkg::TEMP_W-1:0] m_axis_tdata,
    input  logic                              m_axis_tlast
);

    // The result channel is empty when reset is released.
    `HDS_ASSERT_IMPLY(a_idle_after_reset, clk, rst_n, $rose(rst_n), !m_axis_tvalid,
        "result word right after reset")

    // A stalled result word keeps its value and its last mark.
    `HDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result word changed")

    // Configuration writes are never refused.
    `HDS_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready, "configuration write refused")

endmodule

bind heat_diffusion_stencil_pass_top hds_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
